// ===== src/satq_pkg.sv =====
package satq_pkg;

	// Field widths of one input item and one result item.
	localparam int unsigned TIME_W  = 63;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned CB_W    = 8;
	localparam int unsigned RELOAD_W = 31;
	localparam int unsigned S_DATA_W = 264;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 48;

	// Restoring remainder takes one quotient bit per step.
	localparam int unsigned DIV_STEPS = TIME_W;

	localparam logic [TIME_W-1:0]   TIME_MAX   = {TIME_W{1'b1}};
	localparam logic [RELOAD_W-1:0] RELOAD_MAX = 31'h7FFF_FFFF;

	// Request kinds carried in tuser.
	typedef enum logic [1:0] {
		MODE_ONESHOT  = 2'd0,
		MODE_PERIODIC = 2'd1,
		MODE_CANCEL   = 2'd2,
		MODE_EXPIRE   = 2'd3
	} mode_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE      = 5'd0,
		OP_LOAD      = 5'd1,
		OP_RD_SLOT   = 5'd2,
		OP_UNL_A     = 5'd3,
		OP_UNL_B     = 5'd4,
		OP_SET       = 5'd5,
		OP_PER_START = 5'd6,
		OP_DIV_STEP  = 5'd7,
		OP_FIRE      = 5'd8,
		OP_INS_INIT  = 5'd9,
		OP_RD_CUR    = 5'd10,
		OP_INS_STEP  = 5'd11,
		OP_INS_B1    = 5'd12,
		OP_INS_TAIL  = 5'd13,
		OP_LINK      = 5'd14,
		OP_RD_HEAD   = 5'd15,
		OP_EXP_CHK   = 5'd16,
		OP_RELOAD    = 5'd17,
		OP_OUT       = 5'd18
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  slot_ok;
		logic  slot_armed;
		logic  head_none;
		logic  cur_none;
		logic  rd_gt;
		logic  early;
		logic  per_nz;
		logic  per_direct;
		logic  div_last;
		logic  retime_head;
		logic  out_free;
	} status_t;

endpackage

// ===== src/satq_ctrl.sv =====
module satq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  satq_pkg::status_t stat,
	output satq_pkg::cmd_t    cmd
);
	import satq_pkg::*;

	typedef enum logic [18:0] {
		ST_IDLE     = (19'd1 << 0),
		ST_DISPATCH = (19'd1 << 1),
		ST_UNL_RD   = (19'd1 << 2),
		ST_UNL_A    = (19'd1 << 3),
		ST_UNL_B    = (19'd1 << 4),
		ST_SET      = (19'd1 << 5),
		ST_PER      = (19'd1 << 6),
		ST_DIV      = (19'd1 << 7),
		ST_FIRE     = (19'd1 << 8),
		ST_INS0     = (19'd1 << 9),
		ST_INS_RD   = (19'd1 << 10),
		ST_INS_CMP  = (19'd1 << 11),
		ST_INS_B1   = (19'd1 << 12),
		ST_INS_TAIL = (19'd1 << 13),
		ST_LINK     = (19'd1 << 14),
		ST_EXP_RD   = (19'd1 << 15),
		ST_EXP_CHK  = (19'd1 << 16),
		ST_FINISH   = (19'd1 << 17),
		ST_RELOAD   = (19'd1 << 18)
	} state_t;

	state_t state_q, state_nxt;

	// The block takes an item only between two items.
	assign s_tready = (state_q == ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequencer: next state and the operation for this cycle.
	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.mode == MODE_EXPIRE) begin
					state_nxt = stat.head_none ? ST_FINISH : ST_EXP_RD;
				end else if (!stat.slot_ok) begin
					state_nxt = ST_FINISH;
				end else if (stat.slot_armed) begin
					state_nxt = ST_UNL_RD;
				end else if (stat.mode == MODE_CANCEL) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_SET;
				end
			end
			ST_UNL_RD: begin
				cmd.op    = OP_RD_SLOT;
				state_nxt = ST_UNL_A;
			end
			ST_UNL_A: begin
				cmd.op    = OP_UNL_A;
				state_nxt = ST_UNL_B;
			end
			ST_UNL_B: begin
				cmd.op    = OP_UNL_B;
				state_nxt = (stat.mode == MODE_CANCEL) ? ST_FINISH : ST_SET;
			end
			ST_SET: begin
				cmd.op    = OP_SET;
				state_nxt = (stat.mode == MODE_ONESHOT) ? ST_INS0 : ST_PER;
			end
			ST_PER: begin
				cmd.op    = OP_PER_START;
				state_nxt = stat.per_direct ? ST_INS0 : ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_last) begin
					state_nxt = ST_FIRE;
				end
			end
			ST_FIRE: begin
				cmd.op    = OP_FIRE;
				state_nxt = ST_INS0;
			end
			ST_INS0: begin
				cmd.op    = OP_INS_INIT;
				state_nxt = ST_INS_RD;
			end
			ST_INS_RD: begin
				if (stat.cur_none) begin
					state_nxt = ST_INS_TAIL;
				end else begin
					cmd.op    = OP_RD_CUR;
					state_nxt = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				cmd.op    = OP_INS_STEP;
				state_nxt = stat.rd_gt ? ST_INS_B1 : ST_INS_RD;
			end
			ST_INS_B1: begin
				cmd.op    = OP_INS_B1;
				state_nxt = ST_LINK;
			end
			ST_INS_TAIL: begin
				cmd.op    = OP_INS_TAIL;
				state_nxt = ST_LINK;
			end
			ST_LINK: begin
				cmd.op    = OP_LINK;
				state_nxt = ST_FINISH;
			end
			ST_EXP_RD: begin
				cmd.op    = OP_RD_HEAD;
				state_nxt = ST_EXP_CHK;
			end
			ST_EXP_CHK: begin
				cmd.op = OP_EXP_CHK;
				if (stat.early || !stat.per_nz) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_PER;
				end
			end
			ST_FINISH: begin
				if (stat.retime_head) begin
					cmd.op    = OP_RD_HEAD;
					state_nxt = ST_RELOAD;
				end else if (stat.out_free) begin
					cmd.op    = OP_OUT;
					state_nxt = ST_IDLE;
				end
			end
			ST_RELOAD: begin
				// The reload is latched here; the result leaves from the finish state.
				cmd.op    = OP_RELOAD;
				state_nxt = ST_FINISH;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/satq_dp.sv =====
module satq_dp #(
	parameter int unsigned ALARM_SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  satq_pkg::cmd_t                   cmd,
	output satq_pkg::status_t                stat,
	input  logic [satq_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [satq_pkg::S_USER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [satq_pkg::M_DATA_W-1:0]    m_tdata
);
	import satq_pkg::*;

	localparam int unsigned SW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int unsigned LW = $clog2(ALARM_SLOTS + 1);
	localparam logic [LW-1:0] NONE = LW'(ALARM_SLOTS);
	localparam int unsigned CW = $clog2(DIV_STEPS);

	// Slot storage.
	logic [TIME_W-1:0] mem_fire  [ALARM_SLOTS];
	logic [TIME_W-1:0] mem_per   [ALARM_SLOTS];
	logic [TIME_W-1:0] mem_start [ALARM_SLOTS];
	logic [CB_W-1:0]   mem_cb    [ALARM_SLOTS];
	logic [LW-1:0]     mem_next  [ALARM_SLOTS];
	logic [LW-1:0]     mem_prev  [ALARM_SLOTS];

	logic [ALARM_SLOTS-1:0] armed_q;
	logic [LW-1:0] head_q, tail_q;

	// Item registers.
	mode_t             mode_q;
	logic [TIME_W-1:0] now_q, delay_q, start_q, per_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CB_W-1:0]   cb_q;

	// Working registers.
	logic [TIME_W-1:0] rd_fire_q, rd_per_q, rd_start_q;
	logic [CB_W-1:0]   rd_cb_q;
	logic [LW-1:0]     rd_next_q, rd_prev_q;
	logic [TIME_W-1:0] per_w_q, start_w_q, new_fire_q, num_q;
	logic [TIME_W:0]   rem_q;
	logic [CW-1:0]     cnt_q;
	logic [SW-1:0]     ins_q;
	logic [LW-1:0]     cur_q, pv_q;
	logic              retime_q, fired_q, rv_q;
	logic [SW-1:0]     fslot_q;
	logic [CB_W-1:0]   fcb_q;
	logic [RELOAD_W-1:0] reload_q;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_q;

	logic [SW-1:0] s_idx;
	logic          slot_ok;

	assign s_idx   = SW'(slot_q);
	assign slot_ok = (32'(slot_q) < ALARM_SLOTS);

	// Arithmetic for fire times, the divider step and the reload value.
	logic [TIME_W:0]   sum_once, sum_per, div_try;
	logic              div_ge;
	logic [TIME_W-1:0] delta;
	logic [TIME_W-1:0] once_fire;

	assign sum_once  = {1'b0, now_q} + {1'b0, delay_q};
	assign once_fire = sum_once[TIME_W] ? TIME_MAX : sum_once[TIME_W-1:0];
	assign sum_per   = {1'b0, now_q} - rem_q + {1'b0, per_w_q};
	assign div_try   = {rem_q[TIME_W-1:0], num_q[TIME_W-1]};
	assign div_ge    = (div_try >= {1'b0, per_w_q});
	assign delta     = rd_fire_q - now_q;

	// Status toward the controller.
	always_comb begin
		stat.mode        = mode_q;
		stat.slot_ok     = slot_ok;
		stat.slot_armed  = armed_q[s_idx];
		stat.head_none   = (head_q == NONE);
		stat.cur_none    = (cur_q == NONE);
		stat.rd_gt       = (rd_fire_q > new_fire_q);
		stat.early       = (now_q < rd_fire_q);
		stat.per_nz      = (rd_per_q != '0);
		stat.per_direct  = (start_w_q >= now_q) || (per_w_q == '0);
		stat.div_last    = (cnt_q == CW'(DIV_STEPS - 1));
		stat.retime_head = retime_q && (head_q != NONE);
		stat.out_free    = !out_valid_q || m_tready;
	end

	// Memory write port and read address.
	logic              we_fire, we_per, we_start, we_cb, we_next, we_prev, rd_en;
	logic [SW-1:0]     waddr, raddr;
	logic [TIME_W-1:0] wd_per, wd_start;
	logic [LW-1:0]     wd_next, wd_prev;

	always_comb begin
		we_fire  = 1'b0;
		we_per   = 1'b0;
		we_start = 1'b0;
		we_cb    = 1'b0;
		we_next  = 1'b0;
		we_prev  = 1'b0;
		rd_en    = 1'b0;
		waddr    = ins_q;
		raddr    = head_q[SW-1:0];
		wd_per   = per_q;
		wd_start = start_q;
		wd_next  = NONE;
		wd_prev  = NONE;
		case (cmd.op)
			OP_RD_SLOT: begin
				rd_en = 1'b1;
				raddr = s_idx;
			end
			OP_RD_CUR: begin
				rd_en = 1'b1;
				raddr = cur_q[SW-1:0];
			end
			OP_RD_HEAD: begin
				rd_en = 1'b1;
			end
			OP_UNL_A: begin
				we_prev = (rd_next_q != NONE);
				waddr   = rd_next_q[SW-1:0];
				wd_prev = rd_prev_q;
			end
			OP_UNL_B: begin
				we_next = (rd_prev_q != NONE);
				waddr   = rd_prev_q[SW-1:0];
				wd_next = rd_next_q;
			end
			OP_SET: begin
				we_per   = 1'b1;
				we_start = 1'b1;
				we_cb    = 1'b1;
				waddr    = s_idx;
				if (mode_q == MODE_ONESHOT) begin
					wd_per   = '0;
					wd_start = '0;
				end
			end
			OP_INS_INIT: begin
				we_fire = 1'b1;
			end
			OP_INS_STEP: begin
				we_prev = (rd_fire_q > new_fire_q);
				waddr   = cur_q[SW-1:0];
				wd_prev = LW'(ins_q);
			end
			OP_INS_B1: begin
				we_prev = 1'b1;
				we_next = 1'b1;
				wd_prev = pv_q;
				wd_next = cur_q;
			end
			OP_INS_TAIL: begin
				we_prev = 1'b1;
				we_next = 1'b1;
				wd_prev = tail_q;
				wd_next = NONE;
			end
			OP_LINK: begin
				we_next = (pv_q != NONE);
				waddr   = pv_q[SW-1:0];
				wd_next = LW'(ins_q);
			end
			OP_EXP_CHK: begin
				we_prev = !(now_q < rd_fire_q) && (rd_next_q != NONE);
				waddr   = rd_next_q[SW-1:0];
				wd_prev = NONE;
			end
			default: begin
			end
		endcase
	end

	// Slot memories with registered read data.
	always_ff @(posedge clk) begin
		if (we_fire)  mem_fire[waddr]  <= new_fire_q;
		if (we_per)   mem_per[waddr]   <= wd_per;
		if (we_start) mem_start[waddr] <= wd_start;
		if (we_cb)    mem_cb[waddr]    <= cb_q;
		if (we_next)  mem_next[waddr]  <= wd_next;
		if (we_prev)  mem_prev[waddr]  <= wd_prev;
		if (rd_en) begin
			rd_fire_q  <= mem_fire[raddr];
			rd_per_q   <= mem_per[raddr];
			rd_start_q <= mem_start[raddr];
			rd_cb_q    <= mem_cb[raddr];
			rd_next_q  <= mem_next[raddr];
			rd_prev_q  <= mem_prev[raddr];
		end
	end

	// Output valid: set when a result is written, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// List control state and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= '0;
			head_q      <= NONE;
			tail_q      <= NONE;
			retime_q    <= 1'b0;
			fired_q     <= 1'b0;
			rv_q        <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					retime_q <= 1'b0;
					fired_q  <= 1'b0;
					rv_q     <= 1'b0;
				end
				OP_UNL_A: begin
					if (rd_next_q == NONE) begin
						tail_q <= rd_prev_q;
					end
				end
				OP_UNL_B: begin
					armed_q[s_idx] <= 1'b0;
					if (rd_prev_q == NONE) begin
						head_q <= rd_next_q;
						if (rd_next_q != NONE) begin
							retime_q <= 1'b1;
						end
					end
				end
				OP_INS_INIT: begin
					armed_q[ins_q] <= 1'b1;
				end
				OP_INS_TAIL: begin
					tail_q <= LW'(ins_q);
				end
				OP_LINK: begin
					if (pv_q == NONE) begin
						head_q   <= LW'(ins_q);
						retime_q <= 1'b1;
					end
				end
				OP_EXP_CHK: begin
					if (now_q < rd_fire_q) begin
						retime_q <= 1'b1;
					end else begin
						armed_q[head_q[SW-1:0]] <= 1'b0;
						head_q  <= rd_next_q;
						fired_q <= 1'b1;
						if (rd_next_q == NONE) begin
							tail_q <= NONE;
						end else begin
							retime_q <= 1'b1;
						end
					end
				end
				OP_RELOAD: begin
					rv_q     <= 1'b1;
					retime_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q   <= mode_t'(s_tuser[1:0]);
				now_q    <= s_tdata[62:0];
				slot_q   <= s_tdata[66:63];
				delay_q  <= s_tdata[129:67];
				start_q  <= s_tdata[192:130];
				per_q    <= s_tdata[255:193];
				cb_q     <= s_tdata[263:256];
				fslot_q  <= '0;
				fcb_q    <= '0;
				reload_q <= '0;
			end
			OP_SET: begin
				ins_q      <= s_idx;
				per_w_q    <= per_q;
				start_w_q  <= start_q;
				new_fire_q <= once_fire;
			end
			OP_PER_START: begin
				new_fire_q <= start_w_q;
				rem_q      <= '0;
				num_q      <= now_q - start_w_q;
				cnt_q      <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? (div_try - {1'b0, per_w_q}) : div_try;
				num_q <= {num_q[TIME_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_FIRE: begin
				new_fire_q <= sum_per[TIME_W] ? TIME_MAX : sum_per[TIME_W-1:0];
			end
			OP_INS_INIT: begin
				cur_q <= head_q;
			end
			OP_INS_STEP: begin
				if (rd_fire_q > new_fire_q) begin
					pv_q <= rd_prev_q;
				end else begin
					cur_q <= rd_next_q;
				end
			end
			OP_INS_TAIL: begin
				pv_q <= tail_q;
			end
			OP_EXP_CHK: begin
				ins_q     <= head_q[SW-1:0];
				per_w_q   <= rd_per_q;
				start_w_q <= rd_start_q;
				// Slot and callback are reported only for a popped alarm.
				if (!(now_q < rd_fire_q)) begin
					fslot_q <= head_q[SW-1:0];
					fcb_q   <= rd_cb_q;
				end
			end
			OP_RELOAD: begin
				if (rd_fire_q < now_q) begin
					reload_q <= '0;
				end else if (delta[TIME_W-1:RELOAD_W] != '0) begin
					reload_q <= RELOAD_MAX;
				end else begin
					reload_q <= delta[RELOAD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Result register; a finished result waits here while the next item runs.
	logic [SLOT_W-1:0] fslot_out;
	assign fslot_out = SLOT_W'(fslot_q);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_q <= {2'b00, (head_q == NONE), reload_q, rv_q, fcb_q, fslot_out, fired_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== src/sorted_alarm_timer_queue.sv =====
// Channel   Dir   Fields (lowest bit first)
// s_*       in    tuser: mode; tdata: now_time, alarm_slot, delay_ticks, start_time,
//                 period_ticks, callback_id
// m_*       out   tdata: fired, fired_slot, fired_callback, reload_valid, reload_value,
//                 queue_empty
// One item at a time: it is taken, decoded and finished; an armed slot is unlinked first, an expiry
// reads the head, a retimed head gets a reload computed, and an insert goes either at the tail or
// before a later alarm after passing the entries ahead of it; a periodic alarm may also run the
// bit-serial remainder unit.
// Reset clears the armed flags and the head and tail pointers at once.
// A waiting result stalls the next item only at its end, until m_tready takes the first.
module sorted_alarm_timer_queue #(
	parameter int unsigned ALARM_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now_time[62:0], alarm_slot[66:63], delay_ticks[129:67], start_time[192:130],
	// period_ticks[255:193], callback_id[263:256]
	input  logic [satq_pkg::S_DATA_W-1:0] s_tdata,
	// mode[1:0]
	input  logic [satq_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// fired[0], fired_slot[4:1], fired_callback[12:5], reload_valid[13],
	// reload_value[44:14], queue_empty[45], zero fill[47:46]
	output logic [satq_pkg::M_DATA_W-1:0] m_tdata
);
	import satq_pkg::*;

	cmd_t    cmd;
	status_t stat;

	satq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	satq_dp #(
		.ALARM_SLOTS (ALARM_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== src/satq_check.sv =====
module satq_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [satq_pkg::M_DATA_W-1:0] m_tdata
);
	import satq_pkg::*;

	// A result that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// The block is not ready in the cycle after it takes an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// Slot and callback are zero unless an alarm fired.
	a_fired: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[12:1] == 12'd0)
		else $error("fired fields set without firing");

	// A reload is only given for a remaining head alarm.
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[13] && m_tdata[45]) && (m_tdata[13] || m_tdata[44:14] == 31'd0))
		else $error("reload inconsistent with queue state");

endmodule

bind sorted_alarm_timer_queue satq_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/tb_sorted_alarm_timer_queue.sv =====
module tb_sorted_alarm_timer_queue;
	import satq_pkg::*;

	localparam int unsigned NSLOTS = 16;
	localparam logic [4:0] NO_SLOT = 5'd16;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned RANDOM_ITEMS = 1680;
	localparam logic [62:0] T_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	// One request item, as the sender sees it.
	typedef struct packed {
		mode_t       mode;
		logic [62:0] now;
		logic [3:0]  slot;
		logic [62:0] delay;
		logic [62:0] start;
		logic [62:0] period;
		logic [7:0]  cb;
	} alarm_req_t;

	// One result item; the layout matches m_tdata, fired in bit 0.
	typedef struct packed {
		logic [1:0]  pad;
		logic        qempty;
		logic [30:0] rval;
		logic        rvalid;
		logic [7:0]  fcb;
		logic [3:0]  fslot;
		logic        fired;
	} alarm_res_t;

	// Directed stimulus row; typed rows carry their own expected result.
	typedef struct {
		alarm_req_t req;
		bit         typed;
		alarm_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	sorted_alarm_timer_queue dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Shadow copy of the alarm list.
	bit        armed[NSLOTS];
	bit [63:0] fire_at[NSLOTS];
	bit [63:0] per_of[NSLOTS];
	bit [63:0] start_of[NSLOTS];
	bit [7:0]  cb_of[NSLOTS];
	bit [4:0]  next_of[NSLOTS];
	bit [4:0]  prev_of[NSLOTS];
	bit [4:0]  head_idx = NO_SLOT;
	bit [4:0]  tail_idx = NO_SLOT;

	alarm_res_t pending_results[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// Set by the sender to start the long receiver hold-off.
	bit hold_go = 1'b0;

	function automatic bit [63:0] clamp63(bit [63:0] v);
		return (v > {1'b0, T_MAX}) ? {1'b0, T_MAX} : v;
	endfunction

	// Next aligned fire time of a periodic alarm after now; the start itself if not before now or period zero.
	function automatic bit [63:0] next_periodic(bit [63:0] st, bit [63:0] pd, bit [63:0] now);
		bit [63:0] k;
		if (st >= now || pd == 0)
			return st;
		k = (now - st) / pd + 1;
		return clamp63(st + pd * k);
	endfunction

	function automatic bit [30:0] reload_ticks(bit [63:0] fire, bit [63:0] now);
		bit [63:0] d;
		if (fire < now)
			return '0;
		d = fire - now;
		if (d < 64'h8000_0000)
			return d[30:0];
		return RELOAD_MAX;
	endfunction

	// Removes an armed slot; returns 1 when a remaining slot became the head.
	function automatic bit unlink_alarm(int s);
		bit [4:0] nx = next_of[s];
		bit [4:0] pv = prev_of[s];
		bit retime = 0;
		if (nx >= NO_SLOT)
			tail_idx = pv;
		else
			prev_of[nx] = pv;
		if (pv < NO_SLOT) begin
			next_of[pv] = nx;
		end else begin
			head_idx = nx;
			retime = (nx < NO_SLOT);
		end
		armed[s] = 0;
		return retime;
	endfunction

	// Ordered insert after equal fire times; returns 1 when the slot became the head.
	function automatic bit insert_alarm(int s, bit [63:0] fire);
		bit [4:0] cur = head_idx;
		bit [4:0] pv;
		int guard = 0;
		fire_at[s] = fire;
		armed[s] = 1;
		while (cur < NO_SLOT && guard < NSLOTS) begin
			if (fire_at[cur] > fire) begin
				pv = prev_of[cur];
				prev_of[s] = pv;
				prev_of[cur] = s[4:0];
				next_of[s] = cur;
				if (pv < NO_SLOT) begin
					next_of[pv] = s[4:0];
					return 0;
				end
				head_idx = s[4:0];
				return 1;
			end
			cur = next_of[cur];
			guard++;
		end
		next_of[s] = NO_SLOT;
		pv = tail_idx;
		tail_idx = s[4:0];
		prev_of[s] = pv;
		if (pv < NO_SLOT) begin
			next_of[pv] = s[4:0];
			return 0;
		end
		head_idx = s[4:0];
		return 1;
	endfunction

	// Applies one request to the shadow list and returns the result it yields.
	function automatic alarm_res_t apply_alarm_req(alarm_req_t r);
		alarm_res_t o = '0;
		bit retime = 0;
		bit [63:0] now = {1'b0, r.now};
		int s = r.slot;
		int h;
		bit [4:0] nx;
		if (r.mode == MODE_EXPIRE) begin
			h = head_idx;
			if (h < NO_SLOT) begin
				if (now < fire_at[h]) begin
					retime = 1;
				end else begin
					nx = next_of[h];
					head_idx = nx;
					if (nx >= NO_SLOT)
						tail_idx = NO_SLOT;
					else
						prev_of[nx] = NO_SLOT;
					armed[h] = 0;
					o.fired = 1;
					o.fslot = h[3:0];
					o.fcb = cb_of[h];
					if (per_of[h] > 0)
						void'(insert_alarm(h, next_periodic(start_of[h], per_of[h], now)));
					retime = (head_idx < NO_SLOT);
				end
			end
		end else begin
			if (armed[s] && unlink_alarm(s))
				retime = 1;
			if (r.mode == MODE_ONESHOT) begin
				per_of[s] = 0;
				start_of[s] = 0;
				cb_of[s] = r.cb;
				if (insert_alarm(s, clamp63(now + {1'b0, r.delay})))
					retime = 1;
			end else if (r.mode == MODE_PERIODIC) begin
				per_of[s] = {1'b0, r.period};
				start_of[s] = {1'b0, r.start};
				cb_of[s] = r.cb;
				if (insert_alarm(s, next_periodic({1'b0, r.start}, {1'b0, r.period}, now)))
					retime = 1;
			end
		end
		if (retime && head_idx < NO_SLOT) begin
			o.rvalid = 1;
			o.rval = reload_ticks(fire_at[head_idx], now);
		end
		o.qempty = (head_idx >= NO_SLOT);
		return o;
	endfunction

	// Offers one item and waits for its handshake.
	task automatic offer_item(alarm_req_t r, bit typed, alarm_res_t typed_res);
		alarm_res_t pred;
		s_tvalid <= 1'b1;
		s_tuser <= r.mode;
		s_tdata <= {r.cb, r.period, r.start, r.delay, r.slot, r.now};
		do @(posedge clk); while (!s_tready);
		pred = apply_alarm_req(r);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic alarm_req_t mk_req(mode_t m, logic [62:0] now, logic [3:0] slot,
			logic [62:0] dly, logic [62:0] st, logic [62:0] pd, logic [7:0] cb);
		alarm_req_t r;
		r.mode = m; r.now = now; r.slot = slot; r.delay = dly;
		r.start = st; r.period = pd; r.cb = cb;
		return r;
	endfunction

	function automatic logic [62:0] rand63();
		return 63'({$urandom, $urandom});
	endfunction

	// Random request, mostly coherent in time so that alarms really come due.
	logic [62:0] sim_now = 63'd1000;
	function automatic alarm_req_t random_req();
		alarm_req_t r;
		int pick = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0) begin
			r = mk_req(mode_t'($urandom_range(0, 3)), rand63(), 4'($urandom_range(0, 15)),
				rand63(), rand63(), rand63(), 8'($urandom_range(0, 255)));
			return r;
		end
		sim_now = sim_now + $urandom_range(0, 300);
		r = mk_req(MODE_ONESHOT, sim_now, 4'($urandom_range(0, 15)),
			63'($urandom_range(0, 600)),
			sim_now - $urandom_range(0, 500) + $urandom_range(0, 200),
			63'($urandom_range(1, 250)), 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			r.delay = 63'({$urandom_range(0, 3), $urandom} << $urandom_range(0, 28));
		if ($urandom_range(0, 19) == 0)
			r.period = '0;
		else if ($urandom_range(0, 19) == 0)
			r.period = rand63() >> $urandom_range(0, 40);
		if (pick < 28)
			r.mode = MODE_ONESHOT;
		else if (pick < 50)
			r.mode = MODE_PERIODIC;
		else if (pick < 62)
			r.mode = MODE_CANCEL;
		else begin
			r.mode = MODE_EXPIRE;
			// Often expire exactly when the head is due, or just after.
			if (head_idx < NO_SLOT && $urandom_range(0, 1) == 1) begin
				r.now = fire_at[head_idx][62:0] + $urandom_range(0, 2);
				if (r.now > sim_now && r.now - sim_now < 63'd100000)
					sim_now = r.now;
			end
		end
		return r;
	endfunction

	dir_row_t dir_rows[$];

	// Sender: directed table, then random items in bursts.
	initial begin : sender
		alarm_res_t zr;
		alarm_res_t tr;
		int burst_left;
		int gap;
		zr = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Expiry and cancel on an empty queue change nothing.
		tr = zr; tr.qempty = 1;
		dir_rows.push_back('{mk_req(MODE_EXPIRE, 63'd5, 4'd0, 63'd0, 63'd0, 63'd1, 8'd1),
			1, tr});
		dir_rows.push_back('{mk_req(MODE_CANCEL, 63'd5, 4'd3, 63'd0, 63'd0, 63'd1, 8'd1),
			1, tr});
		// First alarm due now becomes the head with a zero reload.
		tr = zr; tr.rvalid = 1;
		dir_rows.push_back('{mk_req(MODE_ONESHOT, 63'd100, 4'd0, 63'd0, 63'd0, 63'd1, 8'd255),
			1, tr});
		dir_rows.push_back('{mk_req(MODE_ONESHOT, 63'd100, 4'd15, 63'h8000_0000, 63'd0, 63'd1,
			8'd2), 0, zr});
		dir_rows.push_back('{mk_req(MODE_ONESHOT, 63'd100, 4'd1, 63'd100, 63'd0, 63'd1, 8'd3),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_ONESHOT, 63'd100, 4'd2, 63'd100, 63'd0, 63'd1, 8'd4),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_PERIODIC, 63'd1000, 4'd3, 63'd0, 63'd10, 63'd7, 8'd5),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_PERIODIC, 63'd90, 4'd4, 63'd0, 63'd50, 63'd0, 8'd6),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_PERIODIC, 63'd90, 4'd5, 63'd0, 63'd95, 63'd3, 8'd7),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_ONESHOT, 63'd100, 4'd0, 63'd40, 63'd0, 63'd1, 8'd9),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_CANCEL, 63'd100, 4'd1, 63'd0, 63'd0, 63'd1, 8'd1),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_CANCEL, 63'd100, 4'd4, 63'd0, 63'd0, 63'd1, 8'd1),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_EXPIRE, 63'd0, 4'd0, 63'd0, 63'd0, 63'd1, 8'd1),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_EXPIRE, 63'd200, 4'd0, 63'd0, 63'd0, 63'd1, 8'd1),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_ONESHOT, T_MAX, 4'd6, T_MAX, 63'd0, 63'd1, 8'd10),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_PERIODIC, T_MAX, 4'd7, 63'd0, 63'd0, T_MAX, 8'd11),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_PERIODIC, T_MAX - 1, 4'd8, 63'd0, 63'd0, 63'd1, 8'd0),
			0, zr});
		dir_rows.push_back('{mk_req(MODE_ONESHOT, 63'd0, 4'd9, 63'h7FFF_FFFF, 63'd0, 63'd1,
			8'd0), 0, zr});
		for (int i = 0; i < 8; i++)
			dir_rows.push_back('{mk_req(MODE_EXPIRE, T_MAX, 4'd0, 63'd0, 63'd0, 63'd1, 8'd1),
				0, zr});

		foreach (dir_rows[i])
			offer_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
		s_tvalid <= 1'b0;
		wait_drained();

		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 4)
				hold_go = 1'b1;
			if (n == RANDOM_ITEMS / 2) begin
				// Let all pending results drain before the second half.
				s_tvalid <= 1'b0;
				wait_drained();
				@(posedge clk);
			end else if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
			offer_item(random_req(), 0, zr);
		end
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: checks each result, then picks the next ready value.
	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		alarm_res_t got;
		alarm_res_t want;
		rx_cycle <= rx_cycle + 1;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: fired %0d/%0d slot %0d/%0d cb %0d/%0d ",
							"rvalid %0d/%0d rval %0d/%0d empty %0d/%0d pad %0d/%0d"},
							want.fired, got.fired, want.fslot, got.fslot,
							want.fcb, got.fcb, want.rvalid, got.rvalid,
							want.rval, got.rval, want.qempty, got.qempty,
							want.pad, got.pad);
				end
			end
		end
		// One long hold-off once the sender asks; otherwise steady stretches and stalls.
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 5000;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_cycle % 100 < 60) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// ===== sorted_alarm_timer_queue.f =====
src/satq_pkg.sv
src/satq_ctrl.sv
src/satq_dp.sv
src/sorted_alarm_timer_queue.sv
src/satq_check.sv
sim/tb_sorted_alarm_timer_queue.sv
